/* src/encoder_channel_selector_top_assert.svh */
// ----------------------------------------------------------------------------
// Encoder channel selector assertion macros
// Concurrent check macros used at the end of the top level. They expect
// signals named clock and reset in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ENCODER_CHANNEL_SELECTOR_TOP_ASSERT_SVH
`define ENCODER_CHANNEL_SELECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define ECS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("encoder channel selector check failed");

// consequent must hold in the cycle after the antecedent
`define ECS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("encoder channel selector check failed");

`else

`define ECS_ASSERT_SAME(lbl, ante, cons)

`define ECS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/ecs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder channel selector package
// Shared types, register map, reset values and controller encodings.
// ----------------------------------------------------------------------------
package ecs_pkg;

   // default widths of the index and pulse count
   localparam int ECS_INDEX_BITS = 8;
   localparam int ECS_ACCUM_BITS = 16;

   // register map, byte address = 4 * index
   localparam int ECS_ADDR_BITS = 5;
   localparam int ECS_REG_BITS  = 3;
   localparam logic [ECS_REG_BITS-1:0] ECS_REG_DEBOUNCE  = 3'd0;
   localparam logic [ECS_REG_BITS-1:0] ECS_REG_MIN_INTVL = 3'd1;
   localparam logic [ECS_REG_BITS-1:0] ECS_REG_CPD       = 3'd2;
   localparam logic [ECS_REG_BITS-1:0] ECS_REG_MAX_STEPS = 3'd3;
   localparam logic [ECS_REG_BITS-1:0] ECS_REG_CH_COUNT  = 3'd4;
   localparam logic [ECS_REG_BITS-1:0] ECS_REG_BEEP      = 3'd5;
   localparam logic [ECS_REG_BITS-1:0] ECS_REG_IDLE      = 3'd6;

   // register reset values
   localparam logic [15:0] ECS_RST_DEBOUNCE  = 16'd50;
   localparam logic [15:0] ECS_RST_MIN_INTVL = 16'd100;
   localparam logic [7:0]  ECS_RST_CPD       = 8'd4;
   localparam logic [7:0]  ECS_RST_MAX_STEPS = 8'd2;
   localparam logic [7:0]  ECS_RST_CH_COUNT  = 8'd4;
   localparam logic [15:0] ECS_RST_BEEP      = 16'd50;
   localparam logic [31:0] ECS_RST_IDLE      = 32'd300000;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] min_interval_ms;
      logic [7:0]  detent_pulses;
      logic [7:0]  max_steps;
      logic [7:0]  channel_count;
      logic [15:0] beep_ms;
      logic [31:0] idle_timeout_ms;
   } ecs_cfg_type;

   typedef struct packed {
      logic [31:0]       now_ms;
      logic signed [7:0] pulse_delta;
      logic              switch_level;
   } ecs_req_type;

   typedef struct packed {
      logic [7:0] channel_index;
      logic       refresh_request;
      logic       beeper;
      logic       sleep_request;
   } ecs_rsp_type;

   // controller states
   typedef enum logic [1:0] {
      ECS_IDLE,
      ECS_CHECK,
      ECS_DIVIDE,
      ECS_APPLY
   } ecs_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic check;
      logic div_step;
      logic apply;
   } ecs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rot_go;
      logic div_last;
      logic out_free;
   } ecs_sts_type;

endpackage
`default_nettype wire

/* src/ecs_csr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder channel selector register file
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module ecs_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [ecs_pkg::ECS_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]                      pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready,
   output ecs_pkg::ecs_cfg_type                  cfg
);
   import ecs_pkg::*;

   ecs_cfg_type cfg_ff;
   ecs_cfg_type cfg_in;
   logic [ECS_REG_BITS-1:0] reg_sel;
   logic wr_en;

   assign pready  = 1'b1;
   assign reg_sel = paddr[ECS_ADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            ECS_REG_DEBOUNCE:  cfg_in.debounce_ms       = pwdata[15:0];
            ECS_REG_MIN_INTVL: cfg_in.min_interval_ms   = pwdata[15:0];
            ECS_REG_CPD:       cfg_in.detent_pulses     = pwdata[7:0];
            ECS_REG_MAX_STEPS: cfg_in.max_steps         = pwdata[7:0];
            ECS_REG_CH_COUNT:  cfg_in.channel_count     = pwdata[7:0];
            ECS_REG_BEEP:      cfg_in.beep_ms           = pwdata[15:0];
            ECS_REG_IDLE:      cfg_in.idle_timeout_ms   = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms       <= ECS_RST_DEBOUNCE;
         cfg_ff.min_interval_ms   <= ECS_RST_MIN_INTVL;
         cfg_ff.detent_pulses     <= ECS_RST_CPD;
         cfg_ff.max_steps         <= ECS_RST_MAX_STEPS;
         cfg_ff.channel_count     <= ECS_RST_CH_COUNT;
         cfg_ff.beep_ms           <= ECS_RST_BEEP;
         cfg_ff.idle_timeout_ms   <= ECS_RST_IDLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         ECS_REG_DEBOUNCE:  prdata = {16'd0, cfg_ff.debounce_ms};
         ECS_REG_MIN_INTVL: prdata = {16'd0, cfg_ff.min_interval_ms};
         ECS_REG_CPD:       prdata = {24'd0, cfg_ff.detent_pulses};
         ECS_REG_MAX_STEPS: prdata = {24'd0, cfg_ff.max_steps};
         ECS_REG_CH_COUNT:  prdata = {24'd0, cfg_ff.channel_count};
         ECS_REG_BEEP:      prdata = {16'd0, cfg_ff.beep_ms};
         ECS_REG_IDLE:      prdata = cfg_ff.idle_timeout_ms;
         default:           prdata = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

/* src/ecs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder channel selector controller
// Sequences one poll: accept, count/gap check, serial divide when a rotation is due, apply.
// ----------------------------------------------------------------------------
module ecs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire ecs_pkg::ecs_sts_type sts,
   output ecs_pkg::ecs_cmd_type      cmd
);
   import ecs_pkg::*;

   ecs_state_type state_ff;
   ecs_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ECS_IDLE:   if (req_valid) state_in = ECS_CHECK;
         ECS_CHECK:  state_in = sts.rot_go ? ECS_DIVIDE : ECS_APPLY;
         ECS_DIVIDE: if (sts.div_last) state_in = ECS_APPLY;
         ECS_APPLY:  if (sts.out_free) state_in = ECS_IDLE;
         default:    state_in = ECS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ECS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      req_stall    = 1'b1;
      cmd          = '0;
      unique case (state_ff)
         ECS_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ECS_CHECK:  cmd.check    = 1'b1;
         ECS_DIVIDE: cmd.div_step = 1'b1;
         ECS_APPLY:  cmd.apply    = sts.out_free;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

/* src/ecs_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder channel selector datapath
// Pulse count, gap check, restoring divider, index update, beeper and idle
// timer, plus the result register.
// ----------------------------------------------------------------------------
module ecs_dp #(
   parameter int INDEX_BITS = ecs_pkg::ECS_INDEX_BITS,
   parameter int ACCUM_BITS = ecs_pkg::ECS_ACCUM_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ecs_pkg::ecs_cfg_type cfg,
   input  wire ecs_pkg::ecs_cmd_type cmd,
   output ecs_pkg::ecs_sts_type      sts,
   input  wire ecs_pkg::ecs_req_type req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output ecs_pkg::ecs_rsp_type      rsp_payload
);
   import ecs_pkg::*;

   localparam int CNT_BITS = $clog2(ACCUM_BITS + 1);
   localparam int CW       = ((INDEX_BITS > 8) ? INDEX_BITS : 8) + 1;
   localparam logic [CW-1:0] IDX_MASK = CW'((1 << INDEX_BITS) - 1);
   localparam logic [ACCUM_BITS-1:0] ACC_MAX = {1'b0, {(ACCUM_BITS-1){1'b1}}};
   localparam logic [ACCUM_BITS-1:0] ACC_MIN = {1'b1, {(ACCUM_BITS-1){1'b0}}};

   // latched poll
   logic [31:0] now_ff;
   logic [7:0]  delta_ff;
   logic        level_ff;

   // block state
   logic [ACCUM_BITS-1:0] accum_ff,  accum_in;
   logic [31:0]           last_act_ff, last_act_in;
   logic [INDEX_BITS-1:0] chan_ff,   chan_in;
   logic                  prev_sw_ff, prev_sw_in;
   logic                  beep_on_ff, beep_on_in;
   logic [31:0]           beep_end_ff, beep_end_in;
   logic [31:0]           stim_ff,   stim_in;

   // divider
   logic [ACCUM_BITS-1:0] quo_ff, quo_in;
   logic [7:0]            rem_ff, rem_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  rot_ff, rot_in;
   logic                  neg_ff, neg_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   ecs_rsp_type rsp_ff,       rsp_in;

   // check stage signals
   logic [ACCUM_BITS:0]   sum;
   logic [ACCUM_BITS-1:0] acc_sat;
   logic [ACCUM_BITS-1:0] acc_mag;
   logic [31:0]           gap;
   logic                  rot_go;

   // divider step signals
   logic [7:0] divisor;
   logic [8:0] trial;
   logic [8:0] trial_sub;
   logic       fits;

   // apply stage signals
   logic [7:0]            qc;
   logic                  rot_take;
   logic [7:0]            lim8;
   logic [CW-1:0]         lim, cur, step, sum_up, nxt_up, nxt_dn, nxt;
   logic                  moved, press, started;
   logic                  beep_on_n, beep_stop;
   logic [31:0]           end_diff, idle_diff;
   logic [INDEX_BITS-1:0] chan_n;
   logic [CW-1:0]         chan_ext;
   logic                  sleep;

   // saturating count and gap check
   always_comb begin
      sum = {accum_ff[ACCUM_BITS-1], accum_ff}
          + {{(ACCUM_BITS-7){delta_ff[7]}}, delta_ff};
      if (sum[ACCUM_BITS] != sum[ACCUM_BITS-1]) begin
         acc_sat = sum[ACCUM_BITS] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_sat = sum[ACCUM_BITS-1:0];
      end
      acc_mag = acc_sat[ACCUM_BITS-1] ? (~acc_sat + 1'b1) : acc_sat;
      gap     = now_ff - last_act_ff;
      rot_go  = (acc_sat != '0) && (gap >= {16'd0, cfg.debounce_ms})
                && (gap >= {16'd0, cfg.min_interval_ms});
   end

   // one quotient bit per cycle, zero divisor counts as one
   always_comb begin
      divisor   = (cfg.detent_pulses == 8'd0) ? 8'd1 : cfg.detent_pulses;
      trial     = {rem_ff, quo_ff[ACCUM_BITS-1]};
      trial_sub = trial - {1'b0, divisor};
      fits      = trial >= {1'b0, divisor};
   end

   // step clamp and index move
   always_comb begin
      qc = (quo_ff > ACCUM_BITS'(cfg.max_steps)) ? cfg.max_steps : quo_ff[7:0];
      rot_take = rot_ff && (qc != 8'd0);
      lim8 = (cfg.channel_count == 8'd0) ? 8'd0 : cfg.channel_count - 8'd1;
      lim  = (CW'(lim8) > IDX_MASK) ? IDX_MASK : CW'(lim8);
      cur  = CW'(chan_ff);
      step = CW'(qc);
      sum_up = cur + step;
      if (cur < lim) begin
         nxt_up = (sum_up > lim) ? lim : sum_up;
      end else begin
         nxt_up = cur;
      end
      nxt_dn = (cur >= step) ? cur - step : '0;
      nxt    = neg_ff ? nxt_dn : nxt_up;
      moved  = rot_take && (nxt != cur);
      press  = prev_sw_ff && !level_ff;
      started = moved || press;
      priority if (press) begin
         chan_n = '0;
      end else if (moved) begin
         chan_n = nxt[INDEX_BITS-1:0];
      end else begin
         chan_n = chan_ff;
      end
      chan_ext = CW'(chan_n);
   end

   // beeper and idle timer; a fresh beep ends at once only when its length is zero
   always_comb begin
      beep_on_n = beep_on_ff || started;
      end_diff  = now_ff - beep_end_ff;
      beep_stop = started ? (cfg.beep_ms == 16'd0) : !end_diff[31];
      idle_diff = now_ff - stim_ff;
      sleep     = beep_on_n ? (cfg.idle_timeout_ms == 32'd0)
                            : (idle_diff >= cfg.idle_timeout_ms);
   end

   // next state of the registers
   always_comb begin
      accum_in     = accum_ff;
      last_act_in  = last_act_ff;
      chan_in      = chan_ff;
      prev_sw_in   = prev_sw_ff;
      beep_on_in   = beep_on_ff;
      beep_end_in  = beep_end_ff;
      stim_in      = stim_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rot_in       = rot_ff;
      neg_in       = neg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.check) begin
         accum_in = acc_sat;
         rot_in   = rot_go;
         neg_in   = acc_sat[ACCUM_BITS-1];
         quo_in   = acc_mag;
         rem_in   = 8'd0;
         cnt_in   = CNT_BITS'(ACCUM_BITS);
      end

      if (cmd.div_step) begin
         quo_in = {quo_ff[ACCUM_BITS-2:0], fits};
         rem_in = fits ? trial_sub[7:0] : trial[7:0];
         cnt_in = cnt_ff - 1'b1;
      end

      if (cmd.apply) begin
         if (rot_take) begin
            accum_in    = '0;
            last_act_in = now_ff;
         end
         chan_in     = chan_n;
         prev_sw_in  = level_ff;
         beep_on_in  = beep_on_n && !beep_stop;
         beep_end_in = started ? now_ff + {16'd0, cfg.beep_ms} : beep_end_ff;
         stim_in     = beep_on_n ? now_ff : stim_ff;
         rsp_in.channel_index   = chan_ext[7:0];
         rsp_in.refresh_request = started;
         rsp_in.beeper          = beep_on_n && !beep_stop;
         rsp_in.sleep_request   = sleep;
         rsp_valid_in           = 1'b1;
      end
   end

   // control and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         last_act_ff  <= '0;
         chan_ff      <= '0;
         prev_sw_ff   <= 1'b1;
         beep_on_ff   <= 1'b0;
         beep_end_ff  <= '0;
         stim_ff      <= '0;
         cnt_ff       <= '0;
         rot_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         accum_ff     <= accum_in;
         last_act_ff  <= last_act_in;
         chan_ff      <= chan_in;
         prev_sw_ff   <= prev_sw_in;
         beep_on_ff   <= beep_on_in;
         beep_end_ff  <= beep_end_in;
         stim_ff      <= stim_in;
         cnt_ff       <= cnt_in;
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff   <= req_payload.now_ms;
         delta_ff <= req_payload.pulse_delta;
         level_ff <= req_payload.switch_level;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end

   assign sts.rot_go   = rot_go;
   assign sts.div_last = (cnt_ff == CNT_BITS'(1));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

endmodule
`default_nettype wire

/* src/encoder_channel_selector_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder channel selector
// Rotary encoder and push switch front end choosing a channel index.
// ----------------------------------------------------------------------------
// One poll beat in gives one result beat out. A poll is taken only while the
// block is idle and then passes through accept, check and apply when no
// rotation is due, with the restoring divider running between check and
// apply when a rotation is due; it produces one quotient bit per cycle for
// pulses / detent_pulses. The result beat is registered by the apply step.
// The apply step waits while an earlier result still sits stalled in the
// output register. Register writes go through the APB-style port at byte
// address 4 * index, with pready tied high; only write while no poll is in
// flight.
`include "encoder_channel_selector_top_assert.svh"

module encoder_channel_selector_top #(
   parameter int INDEX_BITS = ecs_pkg::ECS_INDEX_BITS,
   parameter int ACCUM_BITS = ecs_pkg::ECS_ACCUM_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // poll channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire ecs_pkg::ecs_req_type              req_payload,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output ecs_pkg::ecs_rsp_type                   rsp_payload,
   // configuration port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [ecs_pkg::ECS_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);
   import ecs_pkg::*;

   ecs_cfg_type cfg;
   ecs_cmd_type cmd;
   ecs_sts_type sts;

   ecs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ecs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ecs_dp #(
      .INDEX_BITS (INDEX_BITS),
      .ACCUM_BITS (ACCUM_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // a taken poll makes the block busy on the next cycle
   `ECS_ASSERT_NEXT(a_busy_after_poll, req_valid && !req_stall, req_stall)

   // a new result only comes out of a busy block
   `ECS_ASSERT_SAME(a_result_from_busy, $rose(rsp_valid), $past(req_stall))

   // with the beeper on the idle timer restarts, so sleep only at zero timeout
   `ECS_ASSERT_SAME(a_no_sleep_while_beeping,
      rsp_valid && rsp_payload.beeper && rsp_payload.sleep_request,
      cfg.idle_timeout_ms == 32'd0)

endmodule
`default_nettype wire
